>>> src/dssd_pkg.sv
package dssd_pkg;

    localparam int VALUE_W  = 28;
    localparam int MAG_W    = 27;
    localparam int SEG_W    = 8;
    localparam int SEL_W    = 8;
    localparam int POS_W    = 3;
    localparam int REM_W    = 4;
    localparam int PC_W     = 3;

    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 31;
    localparam int PROD_W      = MAG_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_TEN = 28'd214748365;
    localparam logic [SEG_W-1:0]   SEG_DASH  = 8'hBF;

    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_IDLE    = 3'd0;
    localparam t_pc PC_DIV_MUL = 3'd1;
    localparam t_pc PC_DIV_REM = 3'd2;
    localparam t_pc PC_DIGIT   = 3'd3;
    localparam t_pc PC_DASH    = 3'd4;

    typedef enum logic [2:0] {
        ACT_WAIT_IN   = 3'd0,
        ACT_DIV_MUL   = 3'd1,
        ACT_DIV_REM   = 3'd2,
        ACT_EMIT_DIG  = 3'd3,
        ACT_EMIT_DASH = 3'd4
    } t_act;

    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_IN   = 2'd1,
        HOLD_OUT  = 2'd2
    } t_hold;

    typedef enum logic {
        BR_NONE = 1'b0,
        BR_MORE = 1'b1
    } t_branch;

    typedef struct packed {
        t_act    act;
        t_hold   hold;
        t_branch branch;
        t_pc     target;
        logic    end_on_last;
    } t_uword;

    typedef struct packed {
        t_act act;
        logic fire;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic more;
        logic last;
    } t_sts;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            PC_IDLE:    w = '{ACT_WAIT_IN,   HOLD_IN,   BR_NONE, PC_IDLE,    1'b0};
            PC_DIV_MUL: w = '{ACT_DIV_MUL,   HOLD_NONE, BR_NONE, PC_IDLE,    1'b0};
            PC_DIV_REM: w = '{ACT_DIV_REM,   HOLD_NONE, BR_NONE, PC_IDLE,    1'b0};
            PC_DIGIT:   w = '{ACT_EMIT_DIG,  HOLD_OUT,  BR_MORE, PC_DIV_MUL, 1'b1};
            PC_DASH:    w = '{ACT_EMIT_DASH, HOLD_OUT,  BR_NONE, PC_IDLE,    1'b1};
            default:    w = '{ACT_WAIT_IN,   HOLD_IN,   BR_NONE, PC_IDLE,    1'b0};
        endcase
        return w;
    endfunction

    function automatic logic [SEG_W-1:0] seg_digit(input logic [REM_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

    function automatic int pow10(input int n);
        int p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

endpackage

>>> src/decimal_seven_segment_shift_driver.sv
// Channel | Direction | Handshake              | Payload
// input   | in        | i_in_valid / o_in_stall | i_value (28 bit signed)
// output  | out       | o_out_valid / i_out_stall | o_segment_code, o_digit_select, o_last
//
// One number yields one to MAX_DIGITS transactions, least significant character first.
// Each digit passes through the steps of the microcoded sequencer: a multiply by the reciprocal
// of ten, a step that takes the quotient and the remainder, then a step that loads the output
// register; a minus sign is loaded by a step of its own, as is the acceptance of a number.
// Synchronous active-low reset returns the sequencer to idle and empties the output register.
// A stalled output holds the sequencer on its emit step; the next number is taken only
// after the last character has been loaded.
module decimal_seven_segment_shift_driver #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [dssd_pkg::VALUE_W-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [dssd_pkg::SEG_W-1:0]       o_segment_code,
    output logic [dssd_pkg::SEL_W-1:0]       o_digit_select,
    output logic                             o_last
);
    import dssd_pkg::*;

    localparam logic [VALUE_W-1:0] LIM_POS = VALUE_W'(pow10(MAX_DIGITS) - 1);
    localparam logic [VALUE_W-1:0] LIM_NEG = VALUE_W'(pow10(MAX_DIGITS - 1) - 1);

    t_ctl ctl;
    t_sts sts;

    logic [MAG_W-1:0] r_q;
    logic [MAG_W-1:0] r_quo;
    logic [REM_W-1:0] r_rem;
    logic             r_neg;
    logic [POS_W-1:0] r_pos;

    logic             r_out_valid;
    logic [SEG_W-1:0] r_seg;
    logic [SEL_W-1:0] r_sel;
    logic             r_last;

    logic               in_acc;
    logic               in_neg;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] lim;
    logic [VALUE_W-1:0] sat;
    logic [PROD_W-1:0]  prod;
    logic [MAG_W-1:0]   quo;
    logic               emit;
    logic [SEG_W-1:0]   n_seg;

    dssd_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_sts  (sts),
        .o_ctl  (ctl)
    );

    always_comb begin
        in_acc = ctl.act == ACT_WAIT_IN && i_in_valid;
        in_neg = i_value[VALUE_W-1];
        mag    = in_neg ? VALUE_W'(-i_value) : VALUE_W'(i_value);
        lim    = in_neg ? LIM_NEG : LIM_POS;
        sat    = (mag > lim) ? lim : mag;
        prod   = PROD_W'(r_q) * PROD_W'(RECIP_TEN);
        quo    = MAG_W'(prod >> RECIP_SHIFT);
        emit   = ctl.fire && (ctl.act == ACT_EMIT_DIG || ctl.act == ACT_EMIT_DASH);
        n_seg  = (ctl.act == ACT_EMIT_DASH) ? SEG_DASH : seg_digit(r_rem);

        sts.in_valid = i_in_valid;
        sts.out_free = !r_out_valid || !i_out_stall;
        sts.more     = r_q != '0;
        sts.last     = ctl.act == ACT_EMIT_DASH || (r_q == '0 && !r_neg) || (&r_pos);
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_q   <= sat[MAG_W-1:0];
            r_neg <= in_neg && (sat != '0);
        end else if (ctl.act == ACT_DIV_REM) begin
            r_q <= r_quo;
        end
        case (ctl.act)
            ACT_DIV_MUL: begin
                r_quo <= quo;
            end
            ACT_DIV_REM: begin
                r_rem <= r_q[REM_W-1:0] - {r_quo[0], 3'b000} - {r_quo[2:0], 1'b0};
            end
            default: begin
            end
        endcase
        if (emit) begin
            r_seg  <= n_seg;
            r_sel  <= SEL_W'(1) << r_pos;
            r_last <= sts.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_pos <= '0;
            end else if (emit) begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    assign o_in_stall     = ctl.act != ACT_WAIT_IN;
    assign o_out_valid    = r_out_valid;
    assign o_segment_code = r_seg;
    assign o_digit_select = r_sel;
    assign o_last         = r_last;

    a_rem_below_ten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.act == ACT_EMIT_DIG |-> r_rem < REM_W'(10))
        else $error("division remainder out of range");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ({1'b0, r_q} <= LIM_POS) && r_pos == '0)
        else $error("saturated magnitude exceeds display range");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_out_valid && $onehot(o_digit_select))
        else $error("loaded frame lacks a one-hot digit select");

endmodule

>>> src/dssd_seq.sv
module dssd_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dssd_pkg::t_sts i_sts,
    output dssd_pkg::t_ctl o_ctl
);
    import dssd_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword uw;
    logic   hold;

    always_comb begin
        uw = ucode(r_pc);
        case (uw.hold)
            HOLD_NONE: hold = 1'b0;
            HOLD_IN:   hold = !i_sts.in_valid;
            HOLD_OUT:  hold = !i_sts.out_free;
            default:   hold = 1'b0;
        endcase
        if (hold) begin
            n_pc = r_pc;
        end else if (uw.end_on_last && i_sts.last) begin
            n_pc = PC_IDLE;
        end else if (uw.branch == BR_MORE && i_sts.more) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
        o_ctl.act  = uw.act;
        o_ctl.fire = !hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> test/decimal_seven_segment_shift_driver_test.sv
`timescale 1ns / 1ps

module decimal_seven_segment_shift_driver_test;

    import dssd_pkg::*;

    localparam int DIGITS      = 8;
    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 95;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 300;

    localparam logic [SEG_W-1:0] DIGIT_SEG [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [SEL_W-1:0] sel;
        logic             last;
    } frame_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      typed;
        logic [3:0]                n;
        logic [63:0]               segs;
    } number_t;

    localparam number_t DIRECTED [N_DIRECTED] = '{
        '{28'sd0,           1'b1, 4'd1, 64'h00000000000000C0},
        '{28'sd99999999,    1'b1, 4'd8, 64'h9090909090909090},
        '{28'sd100000000,   1'b1, 4'd8, 64'h9090909090909090},
        '{28'sd134217727,   1'b1, 4'd8, 64'h9090909090909090},
        '{-28'sd9999999,    1'b1, 4'd8, 64'hBF90909090909090},
        '{-28'sd10000000,   1'b1, 4'd8, 64'hBF90909090909090},
        '{-28'sd134217728,  1'b1, 4'd8, 64'hBF90909090909090},
        '{-28'sd1,          1'b1, 4'd2, 64'h000000000000BFF9},
        '{28'sd1,           1'b0, 4'd0, 64'h0},
        '{28'sd9,           1'b0, 4'd0, 64'h0},
        '{28'sd10,          1'b0, 4'd0, 64'h0},
        '{-28'sd9,          1'b0, 4'd0, 64'h0},
        '{-28'sd10,         1'b0, 4'd0, 64'h0},
        '{28'sd12345678,    1'b0, 4'd0, 64'h0},
        '{-28'sd1234567,    1'b0, 4'd0, 64'h0},
        '{28'sd10000000,    1'b0, 4'd0, 64'h0},
        '{-28'sd1000000,    1'b0, 4'd0, 64'h0},
        '{28'sd9876543,     1'b0, 4'd0, 64'h0},
        '{28'sd5050505,     1'b0, 4'd0, 64'h0},
        '{28'sd1000,        1'b0, 4'd0, 64'h0},
        '{-28'sd100,        1'b0, 4'd0, 64'h0},
        '{28'sd13579246,    1'b0, 4'd0, 64'h0},
        '{28'sd42,          1'b0, 4'd0, 64'h0},
        '{-28'sd7777777,    1'b0, 4'd0, 64'h0},
        '{28'sd99999998,    1'b0, 4'd0, 64'h0}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [VALUE_W-1:0] i_value;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [SEG_W-1:0]          o_segment_code;
    logic [SEL_W-1:0]          o_digit_select;
    logic                      o_last;

    number_t stim_q [$];
    frame_t  frame_q [$];
    frame_t  oldest_frame;

    int n_errors      = 0;
    int n_numbers     = 0;
    int n_frames_seen = 0;
    int idle_cycles   = 0;
    int burst_left    = 1;
    int gap_left      = 0;
    int stall_left    = 0;
    int stall_style   = 0;
    int stall_tick    = 0;

    decimal_seven_segment_shift_driver #(
        .MAX_DIGITS(DIGITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_value(i_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_segment_code(o_segment_code),
        .o_digit_select(o_digit_select),
        .o_last(o_last)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint ten_to(input int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    function automatic void queue_display_frames(input number_t item);
        frame_t                    fr [8];
        logic signed [VALUE_W-1:0] value;
        longint                    v;
        longint                    mag;
        longint                    lim;
        bit                        neg;
        int                        k;
        value = item.value;
        k = 0;
        if (item.typed) begin
            for (k = 0; k < item.n; k++) begin
                fr[k].seg  = item.segs[8*k +: 8];
                fr[k].sel  = SEL_W'(1 << k);
                fr[k].last = 1'b0;
            end
        end else begin
            v   = value;
            neg = v < 0;
            mag = neg ? -v : v;
            lim = neg ? ten_to(DIGITS - 1) - 1 : ten_to(DIGITS) - 1;
            if (mag > lim) begin
                mag = lim;
            end
            if (mag == 0) begin
                neg = 1'b0;
            end
            do begin
                fr[k].seg  = DIGIT_SEG[mag % 10];
                fr[k].sel  = SEL_W'(1 << k);
                fr[k].last = 1'b0;
                mag = mag / 10;
                k++;
            end while (mag != 0 && k < 8);
            if (neg && k < 8) begin
                fr[k].seg  = SEG_DASH;
                fr[k].sel  = SEL_W'(1 << k);
                fr[k].last = 1'b0;
                k++;
            end
        end
        fr[k-1].last = 1'b1;
        for (int i = 0; i < k; i++) begin
            frame_q.push_back(fr[i]);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        n_errors++;
    endtask

    // sender: bursts of transactions separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                queue_display_frames(stim_q.pop_front());
                n_numbers++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(0, 4);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_value    <= stim_q[0].value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_q.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_value    <= stim_q[0].value;
                end
            end
        end
    end

    // receiver: stall styles change in phases of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(20, 200);
            end else begin
                stall_left--;
            end
            stall_tick++;
            case (stall_style)
                0: begin
                    i_out_stall <= 1'b0;
                end
                1: begin
                    i_out_stall <= 1'($urandom_range(0, 1));
                end
                2: begin
                    i_out_stall <= ($urandom_range(0, 7) != 0);
                end
                default: begin
                    i_out_stall <= stall_tick[3];
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_frames_seen++;
            if (frame_q.size() == 0) begin
                report_mismatch($sformatf("unexpected frame seg %h sel %h last %b",
                                          o_segment_code, o_digit_select, o_last));
            end else begin
                oldest_frame = frame_q.pop_front();
                if (o_segment_code !== oldest_frame.seg) begin
                    report_mismatch($sformatf("frame %0d: segment_code %h, want %h",
                                              n_frames_seen, o_segment_code,
                                              oldest_frame.seg));
                end
                if (o_digit_select !== oldest_frame.sel) begin
                    report_mismatch($sformatf("frame %0d: digit_select %h, want %h",
                                              n_frames_seen, o_digit_select,
                                              oldest_frame.sel));
                end
                if (o_last !== oldest_frame.last) begin
                    report_mismatch($sformatf("frame %0d: last %b, want %b",
                                              n_frames_seen, o_last, oldest_frame.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d frames pending",
                     IDLE_LIMIT, frame_q.size());
            $display("decimal_seven_segment_shift_driver_test: FAIL");
            $finish;
        end
    end

    initial begin
        number_t item;
        int      pick;
        int      v;
        int      digits;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_value     = '0;
        i_out_stall = 1'b0;

        for (int i = 0; i < N_DIRECTED; i++) begin
            stim_q.push_back(DIRECTED[i]);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
                digits = $urandom_range(1, DIGITS);
                v = $urandom_range(0, int'(ten_to(digits) - 1));
            end else if (pick <= 5) begin
                digits = $urandom_range(1, DIGITS - 1);
                v = -int'($urandom_range(1, int'(ten_to(digits) - 1)));
            end else if (pick <= 7) begin
                v = $urandom;
            end else if (pick == 8) begin
                v = int'(ten_to(DIGITS)) - 3 + $urandom_range(0, 5);
            end else begin
                v = -int'(ten_to(DIGITS - 1)) - 2 + $urandom_range(0, 4);
            end
            item       = '0;
            item.value = v[VALUE_W-1:0];
            stim_q.push_back(item);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || frame_q.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (frame_q.size() != 0) begin
            report_mismatch($sformatf("%0d frames never arrived", frame_q.size()));
        end
        $display("covered %0d numbers (%0d from the directed table), %0d frames checked",
                 n_numbers, N_DIRECTED, n_frames_seen);
        $display("saturation both ways, zero, all digits and sign, %0d mismatches", n_errors);
        if (n_errors == 0) begin
            $display("decimal_seven_segment_shift_driver_test: PASS");
        end else begin
            $display("decimal_seven_segment_shift_driver_test: FAIL");
        end
        $finish;
    end

endmodule
